### hw/rtl/ecal_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Epoch calendar package
// Constants, reciprocal multipliers, month tables and pipeline control type
// shared by the seconds-to-calendar converter.
// ----------------------------------------------------------------------------
package ecal_pkg;

  localparam int NumStages = 6;

  localparam logic [31:0] LimitSeconds = 32'd4102444800;
  localparam logic [16:0] SecsPerDay   = 17'd86400;
  localparam logic [10:0] DaysPerCycle = 11'd1461;
  localparam logic [11:0] SecsPerHour  = 12'd3600;
  localparam logic [5:0]  SecsPerMin   = 6'd60;
  localparam logic [11:0] BaseYear     = 12'd1970;

  localparam logic [8:0] DaysYear0 = 9'd365;
  localparam logic [9:0] DaysYear1 = 10'd730;
  localparam logic [10:0] DaysYear2 = 11'd1096;

  // Division by 86400 is a shift by 7 followed by a reciprocal of 675.
  localparam int          DayPreShift = 7;
  localparam logic [25:0] DayRecip    = 26'd50903317;
  localparam int          DayShift    = 35;

  localparam logic [16:0] CycleRecip = 17'd91868;
  localparam int          CycleShift = 27;

  localparam logic [17:0] HourRecip = 18'd149131;
  localparam int          HourShift = 29;

  localparam logic [12:0] MinRecip = 13'd4370;
  localparam int          MinShift = 18;

  localparam logic [8:0] MonthStartNormal [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };
  localparam logic [8:0] MonthStartLeap [12] = '{
    9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
    9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335
  };

  typedef struct packed {
    logic [NumStages-1:0] load;
  } ecal_ctrl_t;

  function automatic logic [8:0] month_start(input logic leap, input logic [3:0] idx);
    logic [8:0] res;
    res = 9'd0;
    if (idx < 4'd12) begin
      res = leap ? MonthStartLeap[idx] : MonthStartNormal[idx];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/ecal_day_split.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Epoch calendar day split
// Two stages: whole days by reciprocal multiplication, then the second of the
// day by subtracting the day start.
// ----------------------------------------------------------------------------
module ecal_day_split (
  input  wire logic               clk_i,
  input  wire ecal_pkg::ecal_ctrl_t ctrl_i,
  input  wire logic [31:0]        epoch_seconds_i,
  output logic [15:0]             days_o,
  output logic [16:0]             sod_o
);

  logic [50:0] day_prod;
  logic [15:0] days1_q;
  logic [31:0] secs1_q;
  logic [15:0] days2_q;
  logic [16:0] sod2_q;
  logic [31:0] day_base;

  assign day_prod = 51'(epoch_seconds_i[31:ecal_pkg::DayPreShift]) *
                    51'(ecal_pkg::DayRecip);
  assign day_base = 32'(days1_q) * 32'(ecal_pkg::SecsPerDay);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[0]) begin
      days1_q <= day_prod[ecal_pkg::DayShift +: 16];
      secs1_q <= epoch_seconds_i;
    end
    if (ctrl_i.load[1]) begin
      days2_q <= days1_q;
      sod2_q  <= 17'(secs1_q - day_base);
    end
  end

  assign days_o = days2_q;
  assign sod_o  = sod2_q;

endmodule
`default_nettype wire

### hw/rtl/ecal_date.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Epoch calendar date path
// Four stages: four-year cycle, year within the cycle, month search and day
// of month.
// ----------------------------------------------------------------------------
module ecal_date (
  input  wire logic                 clk_i,
  input  wire ecal_pkg::ecal_ctrl_t ctrl_i,
  input  wire logic [15:0]          days_i,
  output logic [11:0]               year_o,
  output logic [3:0]                month_o,
  output logic [4:0]                day_o
);

  logic [32:0] cyc_prod;
  logic [5:0]  cyc3_q;
  logic [15:0] days3_q;
  logic [10:0] rem;
  logic [5:0]  cyc4_q;
  logic [1:0]  yoff4_q;
  logic        leap4_q;
  logic [8:0]  yday4_q;
  logic [1:0]  yoff_d;
  logic        leap_d;
  logic [8:0]  yday_d;
  logic [3:0]  mon_d;
  logic [11:0] year5_q;
  logic [3:0]  mon5_q;
  logic        leap5_q;
  logic [8:0]  yday5_q;
  logic [11:0] year6_q;
  logic [3:0]  month6_q;
  logic [4:0]  day6_q;

  assign cyc_prod = 33'(days_i) * 33'(ecal_pkg::CycleRecip);
  assign rem = 11'(days3_q - 16'(cyc3_q) * 16'(ecal_pkg::DaysPerCycle));

  always_comb begin
    if (rem < 11'(ecal_pkg::DaysYear0)) begin
      yoff_d = 2'd0;
      leap_d = 1'b0;
      yday_d = 9'(rem);
    end else if (rem < 11'(ecal_pkg::DaysYear1)) begin
      yoff_d = 2'd1;
      leap_d = 1'b0;
      yday_d = 9'(rem - 11'(ecal_pkg::DaysYear0));
    end else if (rem < ecal_pkg::DaysYear2) begin
      yoff_d = 2'd2;
      leap_d = 1'b1;
      yday_d = 9'(rem - 11'(ecal_pkg::DaysYear1));
    end else begin
      yoff_d = 2'd3;
      leap_d = 1'b0;
      yday_d = 9'(rem - ecal_pkg::DaysYear2);
    end
  end

  always_comb begin
    mon_d = 4'd0;
    for (int i = 1; i < 12; i++) begin
      if (yday4_q >= ecal_pkg::month_start(leap4_q, 4'(i))) begin
        mon_d = 4'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[2]) begin
      cyc3_q  <= cyc_prod[ecal_pkg::CycleShift +: 6];
      days3_q <= days_i;
    end
    if (ctrl_i.load[3]) begin
      cyc4_q  <= cyc3_q;
      yoff4_q <= yoff_d;
      leap4_q <= leap_d;
      yday4_q <= yday_d;
    end
    if (ctrl_i.load[4]) begin
      year5_q <= ecal_pkg::BaseYear + 12'({cyc4_q, yoff4_q});
      mon5_q  <= mon_d;
      leap5_q <= leap4_q;
      yday5_q <= yday4_q;
    end
    if (ctrl_i.load[5]) begin
      year6_q  <= year5_q;
      month6_q <= mon5_q + 4'd1;
      day6_q   <= 5'(yday5_q - ecal_pkg::month_start(leap5_q, mon5_q) + 9'd1);
    end
  end

  assign year_o  = year6_q;
  assign month_o = month6_q;
  assign day_o   = day6_q;

endmodule
`default_nettype wire

### hw/rtl/ecal_tod.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Epoch calendar time of day
// Four stages: hour, seconds within the hour, minute and second.
// ----------------------------------------------------------------------------
module ecal_tod (
  input  wire logic                 clk_i,
  input  wire ecal_pkg::ecal_ctrl_t ctrl_i,
  input  wire logic [16:0]          sod_i,
  output logic [4:0]                hour_o,
  output logic [5:0]                minute_o,
  output logic [5:0]                second_o
);

  logic [34:0] hour_prod;
  logic [4:0]  hour3_q;
  logic [16:0] sod3_q;
  logic [4:0]  hour4_q;
  logic [11:0] mos4_q;
  logic [24:0] min_prod;
  logic [4:0]  hour5_q;
  logic [5:0]  min5_q;
  logic [11:0] mos5_q;
  logic [4:0]  hour6_q;
  logic [5:0]  min6_q;
  logic [5:0]  sec6_q;

  assign hour_prod = 35'(sod_i) * 35'(ecal_pkg::HourRecip);
  assign min_prod  = 25'(mos4_q) * 25'(ecal_pkg::MinRecip);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[2]) begin
      hour3_q <= hour_prod[ecal_pkg::HourShift +: 5];
      sod3_q  <= sod_i;
    end
    if (ctrl_i.load[3]) begin
      hour4_q <= hour3_q;
      mos4_q  <= 12'(sod3_q - 17'(hour3_q) * 17'(ecal_pkg::SecsPerHour));
    end
    if (ctrl_i.load[4]) begin
      hour5_q <= hour4_q;
      min5_q  <= min_prod[ecal_pkg::MinShift +: 6];
      mos5_q  <= mos4_q;
    end
    if (ctrl_i.load[5]) begin
      hour6_q <= hour5_q;
      min6_q  <= min5_q;
      sec6_q  <= 6'(mos5_q - 12'(min5_q) * 12'(ecal_pkg::SecsPerMin));
    end
  end

  assign hour_o   = hour6_q;
  assign minute_o = min6_q;
  assign second_o = sec6_q;

endmodule
`default_nettype wire

### hw/rtl/epoch_seconds_to_calendar.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Epoch seconds to calendar
// Converts seconds since 1970-01-01 00:00:00 into date and time of day, valid
// to the end of 2099, in a six-stage pipeline.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake          | Payload
// input   | in        | valid_i / stall_o  | epoch_seconds_i
// output  | out       | valid_o / stall_i  | year_o month_o day_o hour_o
//         |           |                    | minute_o second_o range_error_o
//
// One item may enter every cycle while stall_o is low; the depth is set by the
// chain of reciprocal multipliers.
// Reset clears the stage valid bits only.
// A stall on the output backs up only as far as the first empty stage, so
// bubbles are squeezed out and stall_o rises only when all stages are full.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             stall_o,
  input  wire logic [31:0] epoch_seconds_i,
  output logic             valid_o,
  input  wire logic        stall_i,
  output logic [11:0]      year_o,
  output logic [3:0]       month_o,
  output logic [4:0]       day_o,
  output logic [4:0]       hour_o,
  output logic [5:0]       minute_o,
  output logic [5:0]       second_o,
  output logic             range_error_o
);

  localparam int N = ecal_pkg::NumStages;

  logic [N-1:0] valid_q;
  logic [N-1:0] rng_q;
  logic [N:0]   ready;
  logic [N-1:0] prev_valid;
  logic [N-1:0] prev_rng;
  ecal_pkg::ecal_ctrl_t ctrl;
  logic [15:0]  days;
  logic [16:0]  sod;
  logic [11:0]  year;
  logic [3:0]   month;
  logic [4:0]   day;
  logic [4:0]   hour;
  logic [5:0]   minute;
  logic [5:0]   second;

  always_comb begin
    ready[N] = !stall_i;
    for (int k = N - 1; k >= 0; k--) begin
      ready[k] = !valid_q[k] || ready[k+1];
    end
  end

  assign prev_valid = {valid_q[N-2:0], valid_i};
  assign prev_rng   = {rng_q[N-2:0], (epoch_seconds_i >= ecal_pkg::LimitSeconds)};
  assign ctrl.load  = ready[N-1:0] & prev_valid;
  assign stall_o    = !ready[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < N; k++) begin
        if (ready[k]) begin
          valid_q[k] <= prev_valid[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < N; k++) begin
      if (ctrl.load[k]) begin
        rng_q[k] <= prev_rng[k];
      end
    end
  end

  ecal_day_split u_split (
    .clk_i           (clk_i),
    .ctrl_i          (ctrl),
    .epoch_seconds_i (epoch_seconds_i),
    .days_o          (days),
    .sod_o           (sod)
  );

  ecal_date u_date (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .days_i  (days),
    .year_o  (year),
    .month_o (month),
    .day_o   (day)
  );

  ecal_tod u_tod (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .sod_i    (sod),
    .hour_o   (hour),
    .minute_o (minute),
    .second_o (second)
  );

  assign valid_o       = valid_q[N-1];
  assign range_error_o = rng_q[N-1];
  assign year_o        = rng_q[N-1] ? '0 : year;
  assign month_o       = rng_q[N-1] ? '0 : month;
  assign day_o         = rng_q[N-1] ? '0 : day;
  assign hour_o        = rng_q[N-1] ? '0 : hour;
  assign minute_o      = rng_q[N-1] ? '0 : minute;
  assign second_o      = rng_q[N-1] ? '0 : second;

`ifndef SYNTH
  a_stall_from_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> stall_i)
    else $error("input stalled while output not stalled");

  a_month_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !range_error_o) |-> (month_o >= 4'd1 && month_o <= 4'd12
                                     && day_o >= 5'd1 && year_o >= 12'd1970))
    else $error("date field out of range");

  a_time_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (hour_o < 5'd24 && minute_o < 6'd60 && second_o < 6'd60))
    else $error("time field out of range");

  a_full_when_stalled : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (valid_q == {N{1'b1}}))
    else $error("input stalled with an empty stage");
`endif

endmodule
`default_nettype wire
